// ===== hdl/dqk_pkg.sv =====
// Shared types and constants for the deque with key delete.
// No dependencies; every other file in hdl/ refers to it by scoped name.
package dqk_pkg;

    localparam int DEPTH_DEF = 64;
    localparam int KEY_W     = 32;
    localparam int OPC_W     = 3;
    localparam int STAT_W    = 2;

    typedef enum logic [OPC_W-1:0] {
        OP_INSERT    = 3'd0,
        OP_DEL_FIRST = 3'd1,
        OP_DEL_LAST  = 3'd2,
        OP_DEL_KEY   = 3'd3,
        OP_READ      = 3'd4
    } t_opcode;

    typedef enum logic [STAT_W-1:0] {
        ST_OK       = 2'd0,
        ST_EMPTY    = 2'd1,
        ST_FULL     = 2'd2,
        ST_NOTFOUND = 2'd3
    } t_status;

    // what a cell loads at the next edge
    typedef enum logic [1:0] {
        CELL_HOLD = 2'd0,
        CELL_PREV = 2'd1,
        CELL_NEXT = 2'd2,
        CELL_HEAD = 2'd3
    } t_cell_op;

    typedef enum logic {
        S_IDLE = 1'b0,
        S_READ = 1'b1
    } t_state;

endpackage

// ===== hdl/dqk_if.sv =====
// Valid/ready channel interfaces for the deque: command in, result out.
// Depends on dqk_pkg for field widths.
interface dqk_in_if;
    logic                              valid;
    logic                              ready;
    logic [dqk_pkg::OPC_W-1:0]         opcode;
    logic signed [dqk_pkg::KEY_W-1:0]  key;

    modport source (output valid, output opcode, output key, input ready);
    modport sink   (input valid, input opcode, input key, output ready);
endinterface

interface dqk_out_if;
    logic                              valid;
    logic                              ready;
    logic signed [dqk_pkg::KEY_W-1:0]  value;
    logic [dqk_pkg::STAT_W-1:0]        status;
    logic                              last_of_run;

    modport source (output valid, output value, output status, output last_of_run,
                    input ready);
    modport sink   (input valid, input value, input status, input last_of_run,
                    output ready);
endinterface

// ===== hdl/dqk_cell.sv =====
// One storage cell of the deque chain: holds a key, compares it, and loads
// from a neighbor, the head, or holds. Depends on dqk_pkg.
module dqk_cell (
    input  logic                              i_clk,
    input  dqk_pkg::t_cell_op                 i_op,
    input  logic signed [dqk_pkg::KEY_W-1:0]  i_prev,
    input  logic signed [dqk_pkg::KEY_W-1:0]  i_next,
    input  logic signed [dqk_pkg::KEY_W-1:0]  i_head,
    input  logic signed [dqk_pkg::KEY_W-1:0]  i_key,
    output logic signed [dqk_pkg::KEY_W-1:0]  o_value,
    output logic                              o_match
);

    logic signed [dqk_pkg::KEY_W-1:0] r_value;
    logic signed [dqk_pkg::KEY_W-1:0] n_value;

    always_comb begin
        unique case (i_op)
            dqk_pkg::CELL_HOLD: n_value = r_value;
            dqk_pkg::CELL_PREV: n_value = i_prev;
            dqk_pkg::CELL_NEXT: n_value = i_next;
            dqk_pkg::CELL_HEAD: n_value = i_head;
            default:            n_value = r_value;
        endcase
    end

    always_ff @(posedge i_clk) begin
        r_value <= n_value;
    end

    assign o_value = r_value;
    assign o_match = (r_value == i_key);

endmodule

// ===== hdl/deque_with_key_delete_core.sv =====
// Deque of up to DEPTH signed 32-bit keys with delete by value.
// Uses dqk_pkg, dqk_if (channels) and dqk_cell (one per entry).
//
// Channels: i_in takes one command beat (opcode, key); o_out gives result
// beats (value, status, last_of_run). A beat moves when valid and ready are
// both high. Entry 0 of the cell chain is always the front of the list.
// Insert front, delete first, delete last and delete key each finish in the
// cycle of acceptance: all cells shift or hold together, and for delete key
// every cell compares its entry and a prefix-OR tree marks the cells at and
// after the first match, which then take their right neighbor's entry.
// Their single status beat appears on o_out in the cycle after acceptance, and
// a new command is taken every cycle while o_out is being drained.
// Read-out emits one beat per entry, front to back, one per cycle while o_out
// is drained; the occupied segment of the chain rotates by one cell per beat,
// so after the last beat the list is back in order. A read holds i_in off until
// its last beat is registered; an empty list gives one beat with status empty.
// Unused opcodes give one beat with status ok and change nothing.
// Reset (i_rst_n low at a clock edge) empties the list and drops any
// pending result; entry contents are not cleared. When the receiver stalls,
// the result beat holds in the output register and i_in ready drops.
module deque_with_key_delete_core #(
    parameter int DEPTH = dqk_pkg::DEPTH_DEF
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    dqk_in_if.sink     i_in,
    dqk_out_if.source  o_out
);

    localparam int CNT_W = $clog2(DEPTH + 1);
    localparam int LVL   = $clog2(DEPTH);

    dqk_pkg::t_state   r_state, n_state;
    logic [CNT_W-1:0]  r_count, n_count;
    logic [CNT_W-1:0]  r_remain, n_remain;
    logic              r_out_valid, n_out_valid;
    logic signed [dqk_pkg::KEY_W-1:0] r_out_value, n_out_value;
    dqk_pkg::t_status  r_out_status, n_out_status;
    logic              r_out_last, n_out_last;

    dqk_pkg::t_opcode  w_op;
    logic              w_out_free;
    logic              w_in_ready;
    logic              w_in_fire;
    logic              w_any_hit;

    logic signed [dqk_pkg::KEY_W-1:0] w_value [DEPTH];
    logic [DEPTH-1:0]  w_match;
    logic [DEPTH-1:0]  w_hit;
    logic [DEPTH-1:0]  w_pre [LVL+1];
    dqk_pkg::t_cell_op w_cop [DEPTH];

    assign w_op       = dqk_pkg::t_opcode'(i_in.opcode);
    assign w_out_free = !r_out_valid || o_out.ready;
    assign w_in_ready = (r_state == dqk_pkg::S_IDLE) && w_out_free;
    assign w_in_fire  = i_in.valid && w_in_ready;

    // cell chain
    for (genvar g = 0; g < DEPTH; g++) begin : g_cell
        logic signed [dqk_pkg::KEY_W-1:0] w_prev;
        logic signed [dqk_pkg::KEY_W-1:0] w_next;
        if (g == 0) begin : g_first
            assign w_prev = i_in.key;
        end else begin : g_mid_prev
            assign w_prev = w_value[g-1];
        end
        if (g == DEPTH - 1) begin : g_lastc
            assign w_next = w_value[g];
        end else begin : g_mid_next
            assign w_next = w_value[g+1];
        end
        dqk_cell u_cell (
            .i_clk   (i_clk),
            .i_op    (w_cop[g]),
            .i_prev  (w_prev),
            .i_next  (w_next),
            .i_head  (w_value[0]),
            .i_key   (i_in.key),
            .o_value (w_value[g]),
            .o_match (w_match[g])
        );
        assign w_hit[g] = w_match[g] && (r_count > CNT_W'(g));
    end

    // prefix OR: bit i set when some occupied cell at or before i matches
    always_comb begin
        w_pre[0] = w_hit;
        for (int l = 0; l < LVL; l++) begin
            for (int i = 0; i < DEPTH; i++) begin
                if (i >= (1 << l)) begin
                    w_pre[l+1][i] = w_pre[l][i] | w_pre[l][i - (1 << l)];
                end else begin
                    w_pre[l+1][i] = w_pre[l][i];
                end
            end
        end
    end
    assign w_any_hit = w_pre[LVL][DEPTH-1];

    // next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            dqk_pkg::S_IDLE: begin
                if (w_in_fire && (w_op == dqk_pkg::OP_READ) && (r_count != '0)) begin
                    n_state = dqk_pkg::S_READ;
                end
            end
            dqk_pkg::S_READ: begin
                if (w_out_free && (r_remain == CNT_W'(1))) begin
                    n_state = dqk_pkg::S_IDLE;
                end
            end
            default: n_state = dqk_pkg::S_IDLE;
        endcase
    end

    // datapath control
    always_comb begin
        n_count      = r_count;
        n_remain     = r_remain;
        n_out_valid  = r_out_valid && !o_out.ready;
        n_out_value  = r_out_value;
        n_out_status = r_out_status;
        n_out_last   = r_out_last;
        for (int i = 0; i < DEPTH; i++) begin
            w_cop[i] = dqk_pkg::CELL_HOLD;
        end
        unique case (r_state)
            dqk_pkg::S_IDLE: begin
                if (w_in_fire) begin
                    n_out_valid  = 1'b1;
                    n_out_value  = '0;
                    n_out_status = dqk_pkg::ST_OK;
                    n_out_last   = 1'b1;
                    case (w_op)
                        dqk_pkg::OP_INSERT: begin
                            if (r_count == CNT_W'(DEPTH)) begin
                                n_out_status = dqk_pkg::ST_FULL;
                            end else begin
                                for (int i = 0; i < DEPTH; i++) begin
                                    w_cop[i] = dqk_pkg::CELL_PREV;
                                end
                                n_count = r_count + CNT_W'(1);
                            end
                        end
                        dqk_pkg::OP_DEL_FIRST: begin
                            if (r_count == '0) begin
                                n_out_status = dqk_pkg::ST_EMPTY;
                            end else begin
                                for (int i = 0; i < DEPTH; i++) begin
                                    w_cop[i] = dqk_pkg::CELL_NEXT;
                                end
                                n_count = r_count - CNT_W'(1);
                            end
                        end
                        dqk_pkg::OP_DEL_LAST: begin
                            if (r_count == '0) begin
                                n_out_status = dqk_pkg::ST_EMPTY;
                            end else begin
                                n_count = r_count - CNT_W'(1);
                            end
                        end
                        dqk_pkg::OP_DEL_KEY: begin
                            if (r_count == '0) begin
                                n_out_status = dqk_pkg::ST_EMPTY;
                            end else if (!w_any_hit) begin
                                n_out_status = dqk_pkg::ST_NOTFOUND;
                            end else begin
                                for (int i = 0; i < DEPTH; i++) begin
                                    if (w_pre[LVL][i]) begin
                                        w_cop[i] = dqk_pkg::CELL_NEXT;
                                    end
                                end
                                n_count = r_count - CNT_W'(1);
                            end
                        end
                        dqk_pkg::OP_READ: begin
                            if (r_count == '0) begin
                                n_out_status = dqk_pkg::ST_EMPTY;
                            end else begin
                                // read-out beats come from S_READ
                                n_out_valid = 1'b0;
                                n_remain    = r_count;
                            end
                        end
                        default: ;
                    endcase
                end
            end
            dqk_pkg::S_READ: begin
                if (w_out_free) begin
                    n_out_valid  = 1'b1;
                    n_out_value  = w_value[0];
                    n_out_status = dqk_pkg::ST_OK;
                    n_out_last   = (r_remain == CNT_W'(1));
                    n_remain     = r_remain - CNT_W'(1);
                    // rotate the occupied segment left by one
                    for (int i = 0; i < DEPTH; i++) begin
                        if (r_count == CNT_W'(i + 1)) begin
                            w_cop[i] = dqk_pkg::CELL_HEAD;
                        end else if (r_count > CNT_W'(i + 1)) begin
                            w_cop[i] = dqk_pkg::CELL_NEXT;
                        end
                    end
                end
            end
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= dqk_pkg::S_IDLE;
            r_count     <= '0;
            r_remain    <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_count     <= n_count;
            r_remain    <= n_remain;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_out_value  <= n_out_value;
        r_out_status <= n_out_status;
        r_out_last   <= n_out_last;
    end

    assign i_in.ready        = w_in_ready;
    assign o_out.valid       = r_out_valid;
    assign o_out.value       = r_out_value;
    assign o_out.status      = r_out_status;
    assign o_out.last_of_run = r_out_last;

    a_count_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CNT_W'(DEPTH))
        else $error("entry count above depth");

    a_no_accept_in_read: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == dqk_pkg::S_READ) |-> !w_in_fire)
        else $error("command accepted during read-out");

    a_insert_grows: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_in_fire && (w_op == dqk_pkg::OP_INSERT) && (r_count != CNT_W'(DEPTH)))
        |=> (r_count == $past(r_count) + CNT_W'(1)))
        else $error("insert did not grow the list");

    a_read_ends_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ((r_state == dqk_pkg::S_READ) && w_out_free && (r_remain == CNT_W'(1)))
        |=> ((r_state == dqk_pkg::S_IDLE) && r_out_valid && r_out_last))
        else $error("read-out did not close with a last beat");

    a_read_keeps_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == dqk_pkg::S_READ) |=> $stable(r_count))
        else $error("count changed during read-out");

endmodule
